>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, sampled on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MSSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define MSSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MSSP_ASSERT_IMP(lbl, ante, cons, msg)
`define MSSP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/mssp_pkg.sv
// ----------------------------------------------------------------------------
// mssp_pkg
// shared types and constants of the multi servo slew positioner
// ----------------------------------------------------------------------------
package mssp_pkg;

  localparam int unsigned NUM_SERVOS = 3;
  localparam int unsigned IdxW = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

  localparam int unsigned KindW   = 2;
  localparam int unsigned SelW    = 2;
  localparam int unsigned UsW     = 16;
  localparam int unsigned OffW    = 11;
  localparam int unsigned DutyW   = 12;
  localparam int unsigned ChanW   = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned MulW    = 20;
  localparam int unsigned ProdW   = 2 * MulW;

  localparam int unsigned US_LO    = 800;
  localparam int unsigned US_HI    = 2400;
  localparam int unsigned US_SPAN  = US_HI - US_LO;
  localparam int unsigned DUTY_MAX = 4095;
  localparam int unsigned TICKS    = 50;
  localparam int unsigned US_DEF   = 1500;

  localparam logic [DutyW-1:0] DUTY_RESET = DutyW'(((US_DEF - US_LO) * DUTY_MAX) / US_SPAN);
  localparam logic [DutyW-1:0] STEP_RESET = DutyW'(10);

  // x * 4095 / 1600 = ((x * 819) >> 6) / 5
  localparam logic [MulW-1:0] SCALE_NUM = MulW'(DUTY_MAX / 5);
  localparam int unsigned     DUTY_SH   = 6;
  localparam logic [MulW-1:0] RCP5      = MulW'(52429);
  localparam int unsigned     RCP5_SH   = 18;
  // s * 4095 / 80000 = ((s * 819) >> 7) / 125
  localparam int unsigned     STEP_SH   = 7;
  localparam logic [MulW-1:0] RCP125    = MulW'(536871);
  localparam int unsigned     RCP125_SH = 26;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FifoPtrW   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FifoCntW   = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [KindW-1:0] {
    KIND_TICK   = 2'd0,
    KIND_MOVE   = 2'd1,
    KIND_CFG    = 2'd2,
    KIND_TOGGLE = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHAN_A = 2'd0,
    CFG_CHAN_B = 2'd1,
    CFG_CHAN_C = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    kind_e             kind;
    logic [IdxW-1:0]   idx;
    logic              dir;
    logic [OffW-1:0]   s_off;
    logic [OffW-1:0]   d_off;
    logic [UsW-1:0]    speed;
  } cmd_t;

  typedef struct packed {
    logic                full;
    logic                empty;
    logic [FifoCntW-1:0] count;
  } fifo_status_t;

  typedef struct packed {
    logic in_tick;
    logic cfg_busy;
    logic cfg_start;
    logic emit;
  } back_status_t;

  typedef logic [NUM_SERVOS-1:0][ChanW-1:0] chan_map_t;

endpackage

>>> hdl/mssp_if.sv
// ----------------------------------------------------------------------------
// mssp_if
// valid/ready channels: input items, result items and register writes
// ----------------------------------------------------------------------------
interface mssp_in_if;
  import mssp_pkg::*;

  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [SelW-1:0]  servo_index;
  logic             direction;
  logic [UsW-1:0]   straight_us;
  logic [UsW-1:0]   diverted_us;
  logic [UsW-1:0]   rate_us;

  modport source (output valid, kind, servo_index, direction, straight_us, diverted_us,
                  rate_us, input ready);
  modport sink (input valid, kind, servo_index, direction, straight_us, diverted_us,
                rate_us, output ready);
endinterface

interface mssp_out_if;
  import mssp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ChanW-1:0] channel;
  logic [DutyW-1:0] duty;
  logic             still_moving;
  logic             last;

  modport source (output valid, channel, duty, still_moving, last, input ready);
  modport sink (input valid, channel, duty, still_moving, last, output ready);
endinterface

interface mssp_cfg_if;
  import mssp_pkg::*;

  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ChanW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/mssp_front.sv
// ----------------------------------------------------------------------------
// mssp_front
// accepts input items, drops those for absent servos, clamps pulse widths
// ----------------------------------------------------------------------------
module mssp_front (
  mssp_in_if.sink         in_i,
  input  logic            fifo_full_i,
  output logic            push_o,
  output mssp_pkg::cmd_t  cmd_o
);
  import mssp_pkg::*;

  function automatic logic [OffW-1:0] clamp_off(input logic [UsW-1:0] us);
    logic [OffW-1:0] r;
    if (us < UsW'(US_LO)) begin
      r = '0;
    end else if (us > UsW'(US_HI)) begin
      r = OffW'(US_SPAN);
    end else begin
      r = OffW'(us - UsW'(US_LO));
    end
    return r;
  endfunction

  logic accept;
  logic idx_ok;

  assign in_i.ready = !fifo_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign idx_ok     = (32'(in_i.servo_index) < NUM_SERVOS);

  always_comb begin
    cmd_o.kind  = kind_e'(in_i.kind);
    cmd_o.idx   = IdxW'(in_i.servo_index);
    cmd_o.dir   = in_i.direction;
    cmd_o.s_off = clamp_off(in_i.straight_us);
    cmd_o.d_off = clamp_off(in_i.diverted_us);
    cmd_o.speed = in_i.rate_us;
  end

  // ticks always go through, addressed items only for present servos
  assign push_o = accept && ((kind_e'(in_i.kind) == KIND_TICK) || idx_ok);

endmodule

>>> hdl/mssp_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mssp_cmd_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module mssp_cmd_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  mssp_pkg::cmd_t         cmd_i,
  input  logic                   pop_i,
  output mssp_pkg::cmd_t         head_o,
  output logic                   head_valid_o,
  output mssp_pkg::fifo_status_t status_o
);
  import mssp_pkg::*;

  cmd_t                mem_q [FIFO_DEPTH];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign do_push = push_i && (count_q != FifoCntW'(FIFO_DEPTH));
  assign do_pop  = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign head_valid_o   = (count_q != '0);
  assign status_o.full  = (count_q == FifoCntW'(FIFO_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign status_o.count = count_q;

endmodule

>>> hdl/mssp_back.sv
// ----------------------------------------------------------------------------
// mssp_back
// per-servo state, command execution, tick slewing and result register
// ----------------------------------------------------------------------------
module mssp_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mssp_pkg::cmd_t         head_i,
  input  logic                   head_valid_i,
  output logic                   pop_o,
  input  mssp_pkg::chan_map_t    chan_map_i,
  mssp_out_if.source             out_o,
  output mssp_pkg::back_status_t status_o
);
  import mssp_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_TICK   = 9'b000000010,
    ST_CFG_MS = 9'b000000100,
    ST_CFG_DS = 9'b000001000,
    ST_CFG_MD = 9'b000010000,
    ST_CFG_DD = 9'b000100000,
    ST_CFG_MP = 9'b001000000,
    ST_CFG_DP = 9'b010000000,
    ST_CFG_WR = 9'b100000000
  } back_state_e;

  back_state_e state_q, state_d;

  logic [DutyW-1:0] str_q  [NUM_SERVOS];
  logic [DutyW-1:0] div_q  [NUM_SERVOS];
  logic [DutyW-1:0] step_q [NUM_SERVOS];
  logic [DutyW-1:0] cur_q  [NUM_SERVOS];
  logic [DutyW-1:0] tgt_q  [NUM_SERVOS];

  logic [IdxW-1:0]       tick_idx_q, tick_idx_d;
  logic [NUM_SERVOS-1:0] mask_q, mask_d;
  cmd_t                  cmd_q;
  logic [ProdW-1:0]      prod_q;
  logic [DutyW-1:0]      sdut_q;
  logic [DutyW-1:0]      ddut_q;

  logic                  out_valid_q;
  logic [ChanW-1:0]      out_chan_q;
  logic [DutyW-1:0]      out_duty_q;
  logic                  out_moving_q;
  logic                  out_last_q;

  logic [IdxW-1:0]       addr;
  logic [DutyW-1:0]      rd_str, rd_div, rd_step, rd_cur, rd_tgt;
  logic [DutyW-1:0]      eff_step;
  logic [DutyW-1:0]      diff;
  logic [DutyW-1:0]      cur_nxt;
  logic [DutyW:0]        mid_sum;
  logic [NUM_SERVOS-1:0] moving;
  logic [NUM_SERVOS-1:0] hi_mask;
  logic                  is_last;
  logic                  out_free;
  logic                  emit;
  logic                  advance;
  logic                  tick_done;
  logic [MulW-1:0]       mul_a, mul_b;
  logic [ProdW-1:0]      prod_d;
  logic [DutyW-1:0]      step_new;

  always_comb begin
    case (state_q)
      ST_TICK: addr = tick_idx_q;
      ST_IDLE: addr = head_i.idx;
      default: addr = cmd_q.idx;
    endcase
  end

  assign rd_str  = str_q[addr];
  assign rd_div  = div_q[addr];
  assign rd_step = step_q[addr];
  assign rd_cur  = cur_q[addr];
  assign rd_tgt  = tgt_q[addr];

  // one step toward the target, no overshoot
  always_comb begin
    eff_step = (rd_step == '0) ? DutyW'(1) : rd_step;
    if (rd_cur < rd_tgt) begin
      diff    = rd_tgt - rd_cur;
      cur_nxt = (diff <= eff_step) ? rd_tgt : rd_cur + eff_step;
    end else begin
      diff    = rd_cur - rd_tgt;
      cur_nxt = (diff <= eff_step) ? rd_tgt : rd_cur - eff_step;
    end
  end

  assign mid_sum = {1'b0, rd_str} + {1'b0, rd_div};

  always_comb begin
    for (int j = 0; j < NUM_SERVOS; j++) begin
      moving[j]  = (cur_q[j] != tgt_q[j]);
      hi_mask[j] = mask_q[j] && (int'(tick_idx_q) < j);
    end
  end

  assign is_last   = ~|hi_mask;
  assign out_free  = !out_valid_q || out_o.ready;
  assign emit      = (state_q == ST_TICK) && mask_q[tick_idx_q] && out_free;
  assign advance   = (state_q == ST_TICK) && (!mask_q[tick_idx_q] || out_free);
  assign tick_done = advance && ((tick_idx_q == IdxW'(NUM_SERVOS - 1)) ||
                                 (mask_q[tick_idx_q] && is_last));
  assign pop_o     = (state_q == ST_IDLE) && head_valid_i;

  always_comb begin
    state_d    = state_q;
    tick_idx_d = tick_idx_q;
    mask_d     = mask_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          case (head_i.kind)
            KIND_TICK: begin
              if (|moving) begin
                state_d    = ST_TICK;
                tick_idx_d = '0;
                mask_d     = moving;
              end
            end
            KIND_CFG: state_d = ST_CFG_MS;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_TICK: begin
        if (tick_done) begin
          state_d = ST_IDLE;
        end else if (advance) begin
          tick_idx_d = tick_idx_q + 1'b1;
        end
      end
      ST_CFG_MS: state_d = ST_CFG_DS;
      ST_CFG_DS: state_d = ST_CFG_MD;
      ST_CFG_MD: state_d = ST_CFG_DD;
      ST_CFG_DD: state_d = ST_CFG_MP;
      ST_CFG_MP: state_d = ST_CFG_DP;
      ST_CFG_DP: state_d = ST_CFG_WR;
      ST_CFG_WR: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // shared multiplier for the configure scaling
  always_comb begin
    case (state_q)
      ST_CFG_MS: begin
        mul_a = MulW'(cmd_q.s_off);
        mul_b = SCALE_NUM;
      end
      ST_CFG_DS, ST_CFG_DD: begin
        mul_a = prod_q[DUTY_SH +: MulW];
        mul_b = RCP5;
      end
      ST_CFG_MD: begin
        mul_a = MulW'(cmd_q.d_off);
        mul_b = SCALE_NUM;
      end
      ST_CFG_MP: begin
        mul_a = MulW'(cmd_q.speed);
        mul_b = SCALE_NUM;
      end
      ST_CFG_DP: begin
        mul_a = prod_q[STEP_SH +: MulW];
        mul_b = RCP125;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d   = ProdW'(mul_a) * ProdW'(mul_b);
    step_new = prod_q[RCP125_SH +: DutyW];
    if (step_new == '0) begin
      step_new = DutyW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_idx_q  <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < NUM_SERVOS; j++) begin
        str_q[j]  <= DUTY_RESET;
        div_q[j]  <= DUTY_RESET;
        step_q[j] <= STEP_RESET;
        cur_q[j]  <= DUTY_RESET;
        tgt_q[j]  <= DUTY_RESET;
      end
    end else begin
      state_q    <= state_d;
      tick_idx_q <= tick_idx_d;
      mask_q     <= mask_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o && (head_i.kind == KIND_MOVE)) begin
        tgt_q[addr] <= head_i.dir ? rd_div : rd_str;
      end
      if (pop_o && (head_i.kind == KIND_TOGGLE)) begin
        tgt_q[addr] <= (rd_cur < mid_sum[DutyW:1]) ? rd_div : rd_str;
      end
      if (emit) begin
        cur_q[addr] <= cur_nxt;
      end
      if (state_q == ST_CFG_WR) begin
        str_q[addr]  <= sdut_q;
        div_q[addr]  <= ddut_q;
        step_q[addr] <= step_new;
        cur_q[addr]  <= rd_tgt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && (head_i.kind == KIND_CFG)) begin
      cmd_q <= head_i;
    end
    if (state_q != ST_IDLE && state_q != ST_TICK && state_q != ST_CFG_WR) begin
      prod_q <= prod_d;
    end
    if (state_q == ST_CFG_MD) begin
      sdut_q <= prod_q[RCP5_SH +: DutyW];
    end
    if (state_q == ST_CFG_MP) begin
      ddut_q <= prod_q[RCP5_SH +: DutyW];
    end
    if (emit) begin
      out_chan_q   <= chan_map_i[tick_idx_q];
      out_duty_q   <= cur_nxt;
      out_moving_q <= (cur_nxt != rd_tgt);
      out_last_q   <= is_last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.channel      = out_chan_q;
  assign out_o.duty         = out_duty_q;
  assign out_o.still_moving = out_moving_q;
  assign out_o.last         = out_last_q;

  assign status_o.in_tick   = (state_q == ST_TICK);
  assign status_o.cfg_busy  = (state_q != ST_IDLE) && (state_q != ST_TICK);
  assign status_o.cfg_start = pop_o && (head_i.kind == KIND_CFG);
  assign status_o.emit      = emit;

endmodule

>>> hdl/multi_servo_slew_positioner.sv
// ----------------------------------------------------------------------------
// multi_servo_slew_positioner
// slew-rate limited positioning of three servos on a 12-bit duty scale
// ----------------------------------------------------------------------------
// in_i carries ticks, moves, configures and toggles; out_o results are one
// transaction per servo that moved on a tick, in servo order, with last set
// on the final one. cfg_i writes the three channel number registers and is
// always ready; write it only while no item is in flight.
// An accepted item, unless it is for an absent servo, enters a two-entry
// command queue, which the executing back end pops only while idle. Moves,
// toggles and ticks with no servo moving are handled in the idle state; a
// configure runs the shared multiplier that scales pulse widths and speed in
// six steps, then writes; a tick visits the servos in order, results leaving
// through an output register in the cycle after their servo is visited.
// Reset restores every servo to 1791 duty on both positions, current and
// target, with a step of 10, and channel numbers 0, 1 and 2.
// A stalled receiver holds the tick at the current servo; the queue keeps
// accepting until it is full, then in_i.ready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_servo_slew_positioner (
  input  logic        clk_i,
  input  logic        rst_ni,
  mssp_in_if.sink     in_i,
  mssp_out_if.source  out_o,
  mssp_cfg_if.sink    cfg_i
);
  import mssp_pkg::*;

  logic [ChanW-1:0] chan_a_q;
  logic [ChanW-1:0] chan_b_q;
  logic [ChanW-1:0] chan_c_q;
  chan_map_t        chan_map;
  logic             push;
  cmd_t             cmd;
  cmd_t             head;
  logic             head_valid;
  logic             pop;
  fifo_status_t     fifo_st;
  back_status_t     bk_st;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_a_q <= ChanW'(0);
      chan_b_q <= ChanW'(1);
      chan_c_q <= ChanW'(2);
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_CHAN_A: chan_a_q <= cfg_i.data;
        CFG_CHAN_B: chan_b_q <= cfg_i.data;
        CFG_CHAN_C: chan_c_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // servos past the third report their own index
  always_comb begin
    for (int j = 0; j < NUM_SERVOS; j++) begin
      if (j == 0) begin
        chan_map[j] = chan_a_q;
      end else if (j == 1) begin
        chan_map[j] = chan_b_q;
      end else if (j == 2) begin
        chan_map[j] = chan_c_q;
      end else begin
        chan_map[j] = ChanW'(j);
      end
    end
  end

  mssp_front u_front (
    .in_i        (in_i),
    .fifo_full_i (fifo_st.full),
    .push_o      (push),
    .cmd_o       (cmd)
  );

  mssp_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid),
    .status_o     (fifo_st)
  );

  mssp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .chan_map_i   (chan_map),
    .out_o        (out_o),
    .status_o     (bk_st)
  );

  `MSSP_ASSERT_IMP(a_emit_in_tick, bk_st.emit, bk_st.in_tick, "result emitted outside a tick")
  `MSSP_ASSERT_IMP(a_full_stalls, fifo_st.full, !in_i.ready, "input ready while queue full")
  `MSSP_ASSERT_NXT(a_cfg_runs, bk_st.cfg_start, bk_st.cfg_busy, "configure did not start")

endmodule
